// File: src/mpp_pkg.sv
// Shared types, constants and saturation helpers for the massless particle pusher.
package mpp_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CfgW        = 24;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned SqrtSteps   = 32;

  // Latency of the fixed-depth units; the divider depth follows the fraction width.
  localparam int unsigned MomLat  = 4;
  localparam int unsigned SqrtLat = SqrtSteps + 2;
  localparam int unsigned PosLat  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIME_STEP,
    CFG_DRIFT_SPEED,
    CFG_DIM_COUNT
  } cfg_idx_e;

  typedef logic signed [31:0] word_t;

  // Particle payload that travels along the pipeline next to the arithmetic.
  typedef struct packed {
    word_t [2:0] mom;
    word_t [2:0] pos;
    logic        last;
    logic        clip;
  } carry_t;

  localparam logic signed [63:0] WordMax = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] WordMin = 64'shffff_ffff_8000_0000;

  function automatic word_t sat_word(input logic signed [63:0] v);
    word_t r;
    if (v > WordMax) begin
      r = word_t'(WordMax[31:0]);
    end else if (v < WordMin) begin
      r = word_t'(WordMin[31:0]);
    end else begin
      r = word_t'(v[31:0]);
    end
    return r;
  endfunction

  function automatic logic sat_clips(input logic signed [63:0] v);
    return (v > WordMax) || (v < WordMin);
  endfunction

endpackage

// File: src/mpp_if.sv
// Request channel interfaces for particles in and pushed particles out.
interface mpp_in_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  particle_charge;
  logic signed [31:0] field_e_x;
  logic signed [31:0] field_e_y;
  logic signed [31:0] mom_in_x;
  logic signed [31:0] mom_in_y;
  logic signed [31:0] mom_in_z;
  logic signed [31:0] pos_in_x;
  logic signed [31:0] pos_in_y;
  logic signed [31:0] pos_in_z;
  logic               last_in;

  modport source (
    output valid, particle_charge, field_e_x, field_e_y, mom_in_x, mom_in_y, mom_in_z,
           pos_in_x, pos_in_y, pos_in_z, last_in,
    input  ready
  );
  modport sink (
    input  valid, particle_charge, field_e_x, field_e_y, mom_in_x, mom_in_y, mom_in_z,
           pos_in_x, pos_in_y, pos_in_z, last_in,
    output ready
  );
endinterface

interface mpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mom_out_x;
  logic signed [31:0] mom_out_y;
  logic signed [31:0] mom_out_z;
  logic signed [31:0] pos_out_x;
  logic signed [31:0] pos_out_y;
  logic signed [31:0] pos_out_z;
  logic               zero_momentum;
  logic               saturated;
  logic               last_out;

  modport source (
    output valid, mom_out_x, mom_out_y, mom_out_z, pos_out_x, pos_out_y, pos_out_z,
           zero_momentum, saturated, last_out,
    input  ready
  );
  modport sink (
    input  valid, mom_out_x, mom_out_y, mom_out_z, pos_out_x, pos_out_y, pos_out_z,
           zero_momentum, saturated, last_out,
    output ready
  );
endinterface

// File: src/massless_particle_push.sv
// Throughput: one particle per cycle; the depth comes from the 32-stage square root and the
// FRAC_BITS+1 stage divider, with four kick stages and three position stages around them.
// The whole pipeline advances together and holds while a result waits at the output register.
// Reset (asynchronous, active low) empties the pipeline and sets dt = 0, speed = 1.0, three axes.
module massless_particle_push #(
  parameter int unsigned FRAC_BITS = mpp_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mpp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mpp_pkg::CfgW-1:0]    cfg_data_i,
  mpp_in_if.sink                      req_in_i,
  mpp_out_if.source                   req_out_o
);
  import mpp_pkg::*;

  localparam int unsigned VdW   = 49 - FRAC_BITS;
  localparam logic [48:0] SpeedHalf = 49'd1 << (FRAC_BITS - 1);

  // Configuration registers. The user must write them only while the pipeline is empty; the block does not enforce it.
  logic [CfgW-1:0] time_step_q;
  logic [CfgW-1:0] drift_speed_q;
  logic [1:0]      dim_count_q;
  logic [1:0]      dims_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q   <= '0;
      drift_speed_q <= CfgW'(65536);
      dim_count_q   <= 2'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TIME_STEP:   time_step_q   <= cfg_data_i;
        CFG_DRIFT_SPEED: drift_speed_q <= cfg_data_i;
        CFG_DIM_COUNT:   dim_count_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // A count of zero advances the x axis like a count of one.
  assign dims_eff = (dim_count_q == 2'd0) ? 2'd1 : dim_count_q;

  // The drift per step, round(v*dt/2^F), depends only on configuration. It is registered in
  // speed_prod_q and then in vd_q, long before any particle reaches the position stages.
  logic [47:0]    speed_prod_q;
  logic [48:0]    speed_sum;
  logic [VdW-1:0] vd_q;

  assign speed_sum = {1'b0, speed_prod_q} + SpeedHalf;

  always_ff @(posedge clk_i) begin
    speed_prod_q <= 48'(drift_speed_q) * 48'(time_step_q);
    vd_q         <= speed_sum[48:FRAC_BITS];
  end

  // One enable for every stage: the pipeline moves unless the output holds an untaken result.
  logic   pipe_en;
  logic   pos_valid;
  logic   pos_zero;
  carry_t pos_carry;

  assign pipe_en        = !pos_valid || req_out_o.ready;
  assign req_in_i.ready = pipe_en;

  carry_t         in_carry;
  word_t [1:0]    in_efield;

  always_comb begin
    in_carry.mom[0] = req_in_i.mom_in_x;
    in_carry.mom[1] = req_in_i.mom_in_y;
    in_carry.mom[2] = req_in_i.mom_in_z;
    in_carry.pos[0] = req_in_i.pos_in_x;
    in_carry.pos[1] = req_in_i.pos_in_y;
    in_carry.pos[2] = req_in_i.pos_in_z;
    in_carry.last   = req_in_i.last_in;
    in_carry.clip   = 1'b0;
    in_efield[0]    = req_in_i.field_e_x;
    in_efield[1]    = req_in_i.field_e_y;
  end

  // Momentum kick from the electric field.
  logic   mom_valid;
  carry_t mom_carry;

  mpp_mom_update #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (req_in_i.valid),
    .charge_i    (req_in_i.particle_charge),
    .efield_i    (in_efield),
    .carry_i     (in_carry),
    .time_step_i (time_step_q),
    .valid_o     (mom_valid),
    .carry_o     (mom_carry)
  );

  // Magnitude of the updated momentum.
  logic        sqrt_valid;
  logic [31:0] sqrt_root;
  logic        sqrt_zero;
  carry_t      sqrt_carry;

  mpp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (mom_valid),
    .carry_i (mom_carry),
    .valid_o (sqrt_valid),
    .root_o  (sqrt_root),
    .zero_o  (sqrt_zero),
    .carry_o (sqrt_carry)
  );

  // Unit direction per axis. With a zero magnitude the quotients are junk and go unused.
  logic                    div_valid;
  logic [2:0][FRAC_BITS:0] div_ratio;
  logic                    div_zero;
  carry_t                  div_carry;

  mpp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (sqrt_valid),
    .root_i  (sqrt_root),
    .zero_i  (sqrt_zero),
    .carry_i (sqrt_carry),
    .valid_o (div_valid),
    .ratio_o (div_ratio),
    .zero_o  (div_zero),
    .carry_o (div_carry)
  );

  // Position advance; its last stage is the output register.
  mpp_pos_update #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (div_valid),
    .ratio_i (div_ratio),
    .vd_i    (vd_q),
    .dims_i  (dims_eff),
    .zero_i  (div_zero),
    .carry_i (div_carry),
    .valid_o (pos_valid),
    .zero_o  (pos_zero),
    .carry_o (pos_carry)
  );

  assign req_out_o.valid         = pos_valid;
  assign req_out_o.mom_out_x     = pos_carry.mom[0];
  assign req_out_o.mom_out_y     = pos_carry.mom[1];
  assign req_out_o.mom_out_z     = pos_carry.mom[2];
  assign req_out_o.pos_out_x     = pos_carry.pos[0];
  assign req_out_o.pos_out_y     = pos_carry.pos[1];
  assign req_out_o.pos_out_z     = pos_carry.pos[2];
  assign req_out_o.zero_momentum = pos_zero;
  assign req_out_o.saturated     = pos_carry.clip;
  assign req_out_o.last_out      = pos_carry.last;

`ifndef SYNTHESIS
  // A zero magnitude can only come from an all-zero momentum vector.
  a_zero_means_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_out_o.valid && req_out_o.zero_momentum |->
      req_out_o.mom_out_x == '0 && req_out_o.mom_out_y == '0 && req_out_o.mom_out_z == '0)
    else $error("zero magnitude reported for nonzero momentum");

  // With zero momentum nothing was clipped: momentum is not at a rail and positions hold.
  a_zero_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_out_o.valid && req_out_o.zero_momentum |-> !req_out_o.saturated)
    else $error("saturation flagged on a zero-momentum particle");

  // A held result must stop intake, or a request would be overwritten inside the pipeline.
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_out_o.valid && !req_out_o.ready |-> !req_in_i.ready)
    else $error("input accepted while the output is stalled");
`endif

endmodule

// File: src/mpp_mom_update.sv
// Momentum kick: p += round(q*dt*E/2^F) on x and y, saturated, over four stages.
module mpp_mom_update #(
  parameter int unsigned FRAC_BITS = mpp_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [7:0]         charge_i,
  input  mpp_pkg::word_t [1:0]      efield_i,
  input  mpp_pkg::carry_t           carry_i,
  input  logic [mpp_pkg::CfgW-1:0]  time_step_i,
  output logic                      valid_o,
  output mpp_pkg::carry_t           carry_o
);
  import mpp_pkg::*;

  localparam logic [63:0] RoundHalf = 64'd1 << (FRAC_BITS - 1);

  logic [MomLat-1:0] valid_q;

  logic [7:0]        q_abs;
  logic [31:0]       qdt_d, qdt_q;
  logic [31:0]       eabs_d [2];
  logic [31:0]       eabs_q [2];
  logic [1:0]        neg_d, neg1_q, neg2_q;
  logic [63:0]       mag_q [2];
  logic [63:0]       dmag;
  logic signed [63:0] delta_d [2];
  logic signed [63:0] delta_q [2];
  logic signed [63:0] mom_sum;
  carry_t            c1_q, c2_q, c3_q, c4_d, c4_q;

  // Stage 1: magnitudes and product sign.
  always_comb begin
    q_abs = charge_i[7] ? 8'(-charge_i) : 8'(charge_i);
    qdt_d = 32'(q_abs) * 32'(time_step_i);
    for (int a = 0; a < 2; a++) begin
      eabs_d[a] = efield_i[a][31] ? 32'(-$signed(efield_i[a])) : 32'(efield_i[a]);
      neg_d[a]  = charge_i[7] ^ efield_i[a][31];
    end
  end

  // Stage 3: round to the momentum scale and restore the sign.
  always_comb begin
    dmag = '0;
    for (int a = 0; a < 2; a++) begin
      dmag       = (mag_q[a] + RoundHalf) >> FRAC_BITS;
      delta_d[a] = neg2_q[a] ? -$signed(dmag) : $signed(dmag);
    end
  end

  // Stage 4: add and saturate.
  always_comb begin
    c4_d    = c3_q;
    mom_sum = '0;
    for (int a = 0; a < 2; a++) begin
      mom_sum       = 64'($signed(c3_q.mom[a])) + delta_q[a];
      c4_d.mom[a]   = sat_word(mom_sum);
      c4_d.clip     = c4_d.clip | sat_clips(mom_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[MomLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qdt_q  <= qdt_d;
      neg1_q <= neg_d;
      neg2_q <= neg1_q;
      c1_q   <= carry_i;
      c2_q   <= c1_q;
      c3_q   <= c2_q;
      c4_q   <= c4_d;
      for (int a = 0; a < 2; a++) begin
        eabs_q[a]  <= eabs_d[a];
        mag_q[a]   <= 64'(qdt_q) * 64'(eabs_q[a]);
        delta_q[a] <= delta_d[a];
      end
    end
  end

  assign valid_o = valid_q[MomLat-1];
  assign carry_o = c4_q;

endmodule

// File: src/mpp_sqrt.sv
// Momentum magnitude: sum of squares and a pipelined integer square root, one bit per stage.
module mpp_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mpp_pkg::carry_t carry_i,
  output logic            valid_o,
  output logic [31:0]     root_o,
  output logic            zero_o,
  output mpp_pkg::carry_t carry_o
);
  import mpp_pkg::*;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_state_t;

  function automatic sq_state_t sqrt_step(input sq_state_t s);
    sq_state_t   n;
    logic [35:0] r4;
    logic [35:0] trial;
    logic        ge;
    r4     = {s.rem, s.rad[63:62]};
    trial  = {2'b00, s.root, 2'b01};
    ge     = (r4 >= trial);
    n.rem  = ge ? 34'(r4 - trial) : r4[33:0];
    n.root = {s.root[30:0], ge};
    n.rad  = {s.rad[61:0], 2'b00};
    return n;
  endfunction

  logic [SqrtLat-1:0] valid_q;
  logic [31:0]        p_abs [3];
  logic [62:0]        sq_q [3];
  logic [63:0]        sum_q;
  carry_t             c1_q, c2_q;
  carry_t             c_q  [SqrtSteps];
  sq_state_t          st_d [SqrtSteps];
  sq_state_t          st_q [SqrtSteps];
  sq_state_t          st_init;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p_abs[a] = carry_i.mom[a][31] ? 32'(-$signed(carry_i.mom[a])) : 32'(carry_i.mom[a]);
    end
  end

  always_comb begin
    st_init = '{rad: sum_q, rem: '0, root: '0};
    st_d[0] = sqrt_step(st_init);
    for (int k = 1; k < SqrtSteps; k++) begin
      st_d[k] = sqrt_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[SqrtLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= 63'(64'(p_abs[a]) * 64'(p_abs[a]));
      end
      sum_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
      c1_q  <= carry_i;
      c2_q  <= c1_q;
      c_q[0] <= c2_q;
      for (int k = 1; k < SqrtSteps; k++) begin
        c_q[k] <= c_q[k-1];
      end
      for (int k = 0; k < SqrtSteps; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = valid_q[SqrtLat-1];
  assign root_o  = st_q[SqrtSteps-1].root;
  assign zero_o  = (st_q[SqrtSteps-1].root == '0);
  assign carry_o = c_q[SqrtSteps-1];

endmodule

// File: src/mpp_div.sv
// Direction ratio round(|p|*2^F/m) for three axes by pipelined restoring division.
module mpp_div #(
  parameter int unsigned FRAC_BITS = mpp_pkg::FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [31:0]            root_i,
  input  logic                   zero_i,
  input  mpp_pkg::carry_t        carry_i,
  output logic                   valid_o,
  output logic [2:0][FRAC_BITS:0] ratio_o,
  output logic                   zero_o,
  output mpp_pkg::carry_t        carry_o
);
  import mpp_pkg::*;

  localparam int unsigned QuotW  = FRAC_BITS + 1;
  localparam int unsigned NumW   = 32 + FRAC_BITS;
  localparam int unsigned DivLat = QuotW + 1;

  typedef struct packed {
    logic [31:0]      rem;
    logic [QuotW-1:0] bits;
    logic [QuotW-1:0] quot;
  } lane_t;

  function automatic lane_t div_step(input lane_t s, input logic [31:0] m);
    lane_t       n;
    logic [32:0] t;
    logic        ge;
    t      = {s.rem, s.bits[QuotW-1]};
    ge     = (t >= {1'b0, m});
    n.rem  = ge ? 32'(t - {1'b0, m}) : t[31:0];
    n.bits = {s.bits[QuotW-2:0], 1'b0};
    n.quot = {s.quot[QuotW-2:0], ge};
    return n;
  endfunction

  logic [DivLat-1:0] valid_q;
  logic [DivLat-1:0] zero_q;
  logic [31:0]       p_abs [3];
  logic [NumW-1:0]   num_q [3];
  logic [31:0]       m1_q;
  logic [31:0]       m_q  [QuotW-1];
  carry_t            c_q  [DivLat];
  lane_t             init [3];
  lane_t             lane_d [QuotW][3];
  lane_t             lane_q [QuotW][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p_abs[a] = carry_i.mom[a][31] ? 32'(-$signed(carry_i.mom[a])) : 32'(carry_i.mom[a]);
    end
  end

  // The quotient never exceeds 2^F, so the top of the numerator starts below the divisor.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      init[a]      = '{rem: {1'b0, num_q[a][NumW-1:QuotW]}, bits: num_q[a][QuotW-1:0],
                       quot: '0};
      lane_d[0][a] = div_step(init[a], m1_q);
      for (int j = 1; j < QuotW; j++) begin
        lane_d[j][a] = div_step(lane_q[j-1][a], m_q[j-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[DivLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        num_q[a] <= (NumW'(p_abs[a]) << FRAC_BITS) + NumW'(root_i >> 1);
        for (int j = 0; j < QuotW; j++) begin
          lane_q[j][a] <= lane_d[j][a];
        end
      end
      m1_q   <= root_i;
      m_q[0] <= m1_q;
      for (int j = 1; j < QuotW - 1; j++) begin
        m_q[j] <= m_q[j-1];
      end
      zero_q <= {zero_q[DivLat-2:0], zero_i};
      c_q[0] <= carry_i;
      for (int j = 1; j < DivLat; j++) begin
        c_q[j] <= c_q[j-1];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ratio_o[a] = lane_q[QuotW-1][a].quot;
    end
  end

  assign valid_o = valid_q[DivLat-1];
  assign zero_o  = zero_q[DivLat-1];
  assign carry_o = c_q[DivLat-1];

endmodule

// File: src/mpp_pos_update.sv
// Position step: pos += round(vd*r/2^F) with the momentum sign, per active axis, saturated.
module mpp_pos_update #(
  parameter int unsigned FRAC_BITS = mpp_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2:0][FRAC_BITS:0]   ratio_i,
  input  logic [48-FRAC_BITS:0]     vd_i,
  input  logic [1:0]                dims_i,
  input  logic                      zero_i,
  input  mpp_pkg::carry_t           carry_i,
  output logic                      valid_o,
  output logic                      zero_o,
  output mpp_pkg::carry_t           carry_o
);
  import mpp_pkg::*;

  localparam int unsigned VdW   = 49 - FRAC_BITS;
  localparam int unsigned QuotW = FRAC_BITS + 1;
  localparam int unsigned ProdW = VdW + QuotW;
  localparam logic [ProdW:0] RoundHalf = (ProdW + 1)'(1) << (FRAC_BITS - 1);

  logic [PosLat-1:0]  valid_q;
  logic [ProdW-1:0]   prod_q [3];
  logic [ProdW:0]     inc;
  logic signed [63:0] delta_d [3];
  logic signed [63:0] delta_q [3];
  logic signed [63:0] pos_sum;
  logic [2:0]         active;
  logic               z1_q, z2_q, z3_q;
  carry_t             c1_q, c2_q, c3_d, c3_q;

  always_comb begin
    inc = '0;
    for (int a = 0; a < 3; a++) begin
      inc        = ({1'b0, prod_q[a]} + RoundHalf) >> FRAC_BITS;
      delta_d[a] = c1_q.mom[a][31] ? -$signed(64'(inc)) : $signed(64'(inc));
    end
  end

  // The x axis is always active; y and z follow the configured axis count.
  always_comb begin
    active  = {dims_i == 2'd3, dims_i[1], 1'b1};
    c3_d    = c2_q;
    pos_sum = '0;
    for (int a = 0; a < 3; a++) begin
      pos_sum = 64'($signed(c2_q.pos[a])) + delta_q[a];
      if (active[a] && !z2_q) begin
        c3_d.pos[a] = sat_word(pos_sum);
        c3_d.clip   = c3_d.clip | sat_clips(pos_sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[PosLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a]  <= ProdW'(vd_i) * ProdW'(ratio_i[a]);
        delta_q[a] <= delta_d[a];
      end
      z1_q <= zero_i;
      z2_q <= z1_q;
      z3_q <= z2_q;
      c1_q <= carry_i;
      c2_q <= c1_q;
      c3_q <= c3_d;
    end
  end

  assign valid_o = valid_q[PosLat-1];
  assign zero_o  = z3_q;
  assign carry_o = c3_q;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the massless particle pusher with random handshake stalls.
module tb_top;
  import mpp_pkg::*;

  localparam int unsigned FracBits = FracBitsDef;
  // The first 2-bit register index past the last defined register.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = CfgIdxW'(CFG_DIM_COUNT) + 1'b1;
  // Comfortably more than the pipeline latency.
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned ItemsPerPhase = 220;
  localparam int unsigned NumPhases = 8;

  // One particle as it enters the block.
  typedef struct {
    logic signed [7:0] charge;
    word_t             e_x, e_y;
    word_t             mom[3];
    word_t             pos[3];
    logic              last;
  } particle_t;

  // One pushed particle as it leaves the block.
  typedef struct {
    word_t mom[3];
    word_t pos[3];
    logic  zero_mom;
    logic  clip;
    logic  last;
  } pushed_t;

  // Holds a mirror of the registers, predicts each push, and checks results in order.
  class push_scoreboard;
    longint unsigned step_dt;
    longint unsigned speed;
    int unsigned     axes;
    pushed_t         pending_q[$];
    int unsigned     mismatches;

    function new();
      step_dt    = 0;
      speed      = 64'd65536;
      axes       = 3;
      mismatches = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_TIME_STEP:   step_dt = value;
        CFG_DRIFT_SPEED: speed = value;
        CFG_DIM_COUNT:   axes = value[1:0];
        default: ;
      endcase
    endfunction

    static function longint unsigned magnitude(longint signed v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    static function word_t clamp(longint signed v, ref logic clip);
      if (v > 64'sd2147483647) begin
        clip = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
        clip = 1'b1;
        return 32'sh8000_0000;
      end
      return word_t'(v);
    endfunction

    static function longint unsigned floor_root(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Works out the pushed particle for an accepted request and queues it.
    function void note_request(particle_t p);
      pushed_t         r;
      longint signed   field[2];
      longint signed   kick, mom[3];
      longint unsigned mag, sq, root, vd, ratio, inc;
      int unsigned     active;
      r.clip = 1'b0;
      field[0] = p.e_x;
      field[1] = p.e_y;
      for (int i = 0; i < 3; i++) begin
        mom[i] = p.mom[i];
        r.pos[i] = p.pos[i];
      end
      for (int i = 0; i < 2; i++) begin
        mag = magnitude(p.charge) * step_dt * magnitude(field[i]);
        kick = (mag + (64'd1 << (FracBits - 1))) >> FracBits;
        if ((p.charge < 0) != (field[i] < 0)) kick = -kick;
        mom[i] = clamp(mom[i] + kick, r.clip);
      end
      for (int i = 0; i < 3; i++) r.mom[i] = word_t'(mom[i]);
      sq = 0;
      for (int i = 0; i < 3; i++) sq += magnitude(mom[i]) * magnitude(mom[i]);
      root = floor_root(sq);
      r.zero_mom = (root == 0);
      active = (axes == 0) ? 1 : axes;
      vd = (speed * step_dt + (64'd1 << (FracBits - 1))) >> FracBits;
      if (!r.zero_mom) begin
        for (int i = 0; i < active; i++) begin
          ratio = ((magnitude(mom[i]) << FracBits) + (root >> 1)) / root;
          inc = (vd * ratio + (64'd1 << (FracBits - 1))) >> FracBits;
          r.pos[i] = clamp(longint'(p.pos[i]) + (mom[i] < 0 ? -longint'(inc) : longint'(inc)),
                           r.clip);
        end
      end
      r.last = p.last;
      pending_q.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      mismatches++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Compares one accepted result with the oldest prediction.
    task check_result(pushed_t got);
      pushed_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result, last_out", got.last, 0);
        return;
      end
      want = pending_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.mom[i] !== want.mom[i]) report($sformatf("mom[%0d]", i), got.mom[i], want.mom[i]);
        if (got.pos[i] !== want.pos[i]) report($sformatf("pos[%0d]", i), got.pos[i], want.pos[i]);
      end
      if (got.zero_mom !== want.zero_mom) report("zero_momentum", got.zero_mom, want.zero_mom);
      if (got.clip !== want.clip) report("saturated", got.clip, want.clip);
      if (got.last !== want.last) report("last_out", got.last, want.last);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  // Stalls on both sides are switched off for the final phase.
  bit allow_idle = 1'b1;
  int unsigned stall_left = 0;

  mpp_in_if  in_ch ();
  mpp_out_if out_ch ();

  push_scoreboard board = new();

  massless_particle_push dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_in_i   (in_ch),
    .req_out_o  (out_ch)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.particle_charge = '0;
    in_ch.field_e_x = '0;
    in_ch.field_e_y = '0;
    in_ch.mom_in_x = '0;
    in_ch.mom_in_y = '0;
    in_ch.mom_in_z = '0;
    in_ch.pos_in_x = '0;
    in_ch.pos_in_y = '0;
    in_ch.pos_in_z = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
  end

  // The result side stalls in random bursts while idling is allowed.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every result request that completes is handed to the scoreboard. The values seen here
  // are the ones from before the edge, since the block and the driver both update by NBA.
  always @(posedge clk_i) begin
    pushed_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.mom[0] = out_ch.mom_out_x;
      got.mom[1] = out_ch.mom_out_y;
      got.mom[2] = out_ch.mom_out_z;
      got.pos[0] = out_ch.pos_out_x;
      got.pos[1] = out_ch.pos_out_y;
      got.pos[2] = out_ch.pos_out_z;
      got.zero_mom = out_ch.zero_momentum;
      got.clip = out_ch.saturated;
      got.last = out_ch.last_out;
      board.check_result(got);
    end
  end

  // A field value that favors the extremes, zero and modest magnitudes over uniform noise.
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sd0;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      3: return $urandom_range(0, 2) - 1;
      4, 5: return word_t'($urandom_range(0, 1 << 21)) - (32'sd1 <<< 20);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    p.charge = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4) - 2) : 8'($urandom);
    p.e_x = pick_word();
    p.e_y = pick_word();
    for (int i = 0; i < 3; i++) begin
      p.mom[i] = pick_word();
      p.pos[i] = pick_word();
    end
    // Now and then the momentum stays at zero so that no axis moves.
    if ($urandom_range(0, 9) == 0) begin
      p.mom[0] = 0;
      p.mom[1] = 0;
      p.mom[2] = 0;
      if ($urandom_range(0, 1) != 0) p.charge = 0;
      else begin
        p.e_x = 0;
        p.e_y = 0;
      end
    end
    p.last = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  // Offers one particle, with an optional gap before it, and waits until it is accepted.
  task automatic send_particle(particle_t p);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.particle_charge <= p.charge;
    in_ch.field_e_x <= p.e_x;
    in_ch.field_e_y <= p.e_y;
    in_ch.mom_in_x <= p.mom[0];
    in_ch.mom_in_y <= p.mom[1];
    in_ch.mom_in_z <= p.mom[2];
    in_ch.pos_in_x <= p.pos[0];
    in_ch.pos_in_y <= p.pos[1];
    in_ch.pos_in_z <= p.pos[2];
    in_ch.last_in <= p.last;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_request(p);
  endtask

  // Waits until every prediction has been met and the pipeline has certainly emptied.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes dt, speed and axis count back to back, then a write to the
  // unused index that the block must ignore.
  task automatic write_setup(logic [CfgW-1:0] dt, logic [CfgW-1:0] spd, logic [1:0] dims);
    logic [CfgIdxW-1:0] idx[4];
    logic [CfgW-1:0]    val[4];
    idx = '{CFG_TIME_STEP, CFG_DRIFT_SPEED, CFG_DIM_COUNT, CfgIdxUnused};
    val = '{dt, spd, CfgW'(dims), CfgW'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      board.write_register(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Hand-picked particles at the corners of the charge, field and momentum ranges, then one random particle.
  task automatic send_directed();
    particle_t p;
    for (int k = 0; k < 14; k++) begin
      p = '{charge: 0, e_x: 0, e_y: 0, mom: '{0, 0, 0}, pos: '{0, 0, 0}, last: 0};
      case (k)
        1: p = '{-128, 32'sh7fff_ffff, 32'sh7fff_ffff, '{32'sh7fff_ffff, 32'sh7fff_ffff, 0},
                 '{0, 0, 0}, 0};
        2: p = '{127, 32'sh8000_0000, 32'sh8000_0000, '{32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000}, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1};
        3: p = '{-1, -1, -1, '{0, 0, 0}, '{5, 6, 7}, 0};
        4: p = '{0, 0, 0, '{1, 0, 0}, '{0, 0, 0}, 0};
        5: p = '{0, 0, 0, '{0, 0, 32'sh8000_0000}, '{1, 2, 3}, 1};
        6: p = '{0, 0, 0, '{1000, 2000, 3000}, '{32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh7fff_ffff}, 0};
        7: p = '{0, 0, 0, '{-1000, -2000, -3000}, '{32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000}, 0};
        8: p = '{-128, 32'sh8000_0000, 32'sh7fff_ffff, '{32'sh7fff_ffff, 32'sh8000_0000,
                 32'sh7fff_ffff}, '{-1, -1, -1}, 1};
        9: p = '{1, 32'sh0001_0000, 32'sh0000_8000, '{0, 0, 0}, '{0, 0, 0}, 0};
        10: p = '{127, 32'sh7fff_ffff, 32'sh8000_0000, '{0, 0, 0}, '{0, 0, 0}, 1};
        11: p = '{0, 0, 0, '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
                  '{0, 0, 0}, 0};
        12: p = '{0, 0, 0, '{-1, -1, -1}, '{32'sh7fff_ffff, 0, 32'sh8000_0000}, 0};
        13: p = random_particle();
        default: ;
      endcase
      send_particle(p);
    end
  endtask

  initial begin
    logic [CfgW-1:0] dt_list[NumPhases], spd_list[NumPhases];
    logic [1:0]      dim_list[NumPhases];
    dt_list  = '{24'h01_0000, 24'hff_ffff, 24'h00_0000, 24'h00_0100,
                 24'h00_0001, 24'h00_1999, 24'h00_8000, 24'($urandom)};
    spd_list = '{24'h01_0000, 24'hff_ffff, 24'h00_0000, 24'h04_0000,
                 24'h00_0001, 24'h10_0000, 24'h03_0000, 24'($urandom)};
    dim_list = '{2'd3, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'($urandom)};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A few particles under the reset settings, before anything is written.
    for (int i = 0; i < 6; i++) send_particle(random_particle());
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == NumPhases - 1) allow_idle = 1'b0;
      write_setup(dt_list[ph], spd_list[ph], dim_list[ph]);
      if (ph == 0) send_directed();
      for (int i = 0; i < ItemsPerPhase; i++) send_particle(random_particle());
      wait_drained();
    end

    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
